// ----- rtl/core/sdt_pkg.sv -----
package sdt_pkg;

    // Field widths of one beat on either channel
    localparam int FUNC_W  = 2;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int KEY_W   = 27;
    localparam int AMT_W   = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;

    // Table depth used when the top level is not overridden
    localparam int DEPTH_DEF = 64;

    // Date key scaling: key = year*10000 + month*100 + day
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_SCALE  = 14'd10000;
    localparam logic [6:0]        MONTH_SCALE = 7'd100;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_SEARCH = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_REFUSED   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PUT,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    // One table entry as it sits in memory
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [AMT_W-1:0] amount;
    } t_entry;

    // One result beat handed from the controller to the output register
    typedef struct packed {
        t_status                 status;
        logic signed [AMT_W-1:0] found_amount;
        logic [POS_W-1:0]        position;
        logic [CNT_W-1:0]        entry_count;
    } t_result;

endpackage

// ----- rtl/core/sdt_keygen.sv -----
module sdt_keygen
    import sdt_pkg::*;
(
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [DAY_W-1:0]   i_day,
    output logic [KEY_W-1:0]   o_key
);

    logic [YEAR_W-1:0] year_sat;
    logic [KEY_W-1:0]  year_term;
    logic [KEY_W-1:0]  month_term;

    // Clamp the year so the key always fits its width
    assign year_sat = (i_year > YEAR_MAX) ? YEAR_MAX : i_year;

    // Scale and sum the date fields
    assign year_term  = KEY_W'(year_sat) * KEY_W'(YEAR_SCALE);
    assign month_term = KEY_W'(i_month) * KEY_W'(MONTH_SCALE);
    assign o_key      = year_term + month_term + KEY_W'(i_day);

endmodule

// ----- rtl/core/sdt_store.sv -----
module sdt_store
    import sdt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sdt_ctrl.sv -----
module sdt_ctrl
    import sdt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command beat
    input  logic                    i_start,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [AMT_W-1:0] i_amount,
    output logic                    o_idle,
    // Result beat
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res,
    // Table memory
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output t_entry                  o_mem_wdata,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_raddr,
    input  t_entry                  i_mem_rdata
);

    // Signed one at the width of the search bounds
    localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

    t_state                  r_state, n_state;
    t_func                   r_func, n_func;
    logic [KEY_W-1:0]        r_key, n_key;
    logic signed [AMT_W-1:0] r_amt, n_amt;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_rd_idx, n_rd_idx;
    logic [CW-1:0]           r_left, n_left;
    logic                    r_pend, n_pend;
    logic [AW-1:0]           r_pend_idx, n_pend_idx;
    logic                    r_pend_last, n_pend_last;
    logic                    r_found, n_found;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [CW:0]      r_lo, n_lo;
    logic signed [CW:0]      r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    t_result                 r_res, n_res;

    logic               cnt_full;
    logic               cnt_zero;
    logic               cnt_small;
    logic               rd_ge;
    logic               rd_eq;
    logic               rd_gt;
    logic               probe_empty;
    logic [CW:0]        probe_sum;
    logic [AW-1:0]      probe_mid;
    logic signed [CW:0] count_s;
    logic signed [CW:0] mid_s;
    logic [AW-1:0]      hit_pos;

    // Table occupancy
    assign cnt_full  = (r_count == CW'(DEPTH));
    assign cnt_zero  = (r_count == '0);
    assign cnt_small = (r_count <= CW'(1));
    assign count_s   = $signed((CW+1)'(r_count));

    // Compare the returned entry against the command key
    assign rd_ge = (i_mem_rdata.key >= r_key);
    assign rd_eq = (i_mem_rdata.key == r_key);
    assign rd_gt = (i_mem_rdata.key > r_key);

    // Binary search probe; lo and hi are non-negative whenever a probe is issued
    assign probe_empty = (r_lo > r_hi);
    assign probe_sum   = (CW+1)'(r_lo) + (CW+1)'(r_hi);
    assign probe_mid   = AW'(probe_sum >> 1);
    assign mid_s       = $signed((CW+1)'(r_mid));

    assign hit_pos = r_found ? r_pos : r_pend_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_func)
                    FN_INSERT: begin
                        if (cnt_full) begin
                            n_state = S_DONE;
                        end else if (cnt_zero) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_DELETE: begin
                        n_state = cnt_small ? S_DONE : S_SCAN;
                    end
                    FN_SEARCH: begin
                        n_state = S_PROBE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (r_func == FN_INSERT) begin
                        if (!rd_ge || r_pend_last) begin
                            n_state = S_PUT;
                        end
                    end else if (r_pend_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_PROBE: begin
                n_state = probe_empty ? S_DONE : S_CMP;
            end
            S_CMP: begin
                n_state = rd_eq ? S_DONE : S_PROBE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_func      = r_func;
        n_key       = r_key;
        n_amt       = r_amt;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_pend_last = r_pend_last;
        n_found     = r_found;
        n_pos       = r_pos;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_idx;
        o_idle      = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);

        case (r_state)
            S_IDLE: begin
                // Capture the command beat
                if (i_start) begin
                    n_func = t_func'(i_func);
                    n_key  = i_key;
                    n_amt  = i_amount;
                end
            end
            S_DISPATCH: begin
                // Preset a failed result and the walk pointers
                n_res.status       = ST_NOT_FOUND;
                n_res.found_amount = '0;
                n_res.position     = '0;
                n_res.entry_count  = CNT_W'(r_count);
                n_left             = r_count;
                n_found            = 1'b0;
                n_pos              = '0;
                n_lo               = '0;
                n_hi               = count_s - ONE_S;
                case (r_func)
                    FN_INSERT: begin
                        // Walk down from the last entry
                        n_rd_idx = AW'(r_count - 1'b1);
                        if (cnt_full) begin
                            n_res.status = ST_FULL;
                        end
                    end
                    FN_DELETE: begin
                        // Walk up from the first entry
                        n_rd_idx = '0;
                        if (cnt_small) begin
                            n_res.status = ST_REFUSED;
                        end
                    end
                    default: begin
                        n_rd_idx = '0;
                    end
                endcase
            end
            S_SCAN: begin
                // Issue the next read of the walk
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_rd_idx;
                    n_rd_idx    = (r_func == FN_INSERT) ? r_rd_idx - 1'b1 : r_rd_idx + 1'b1;
                    n_left      = r_left - 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_rd_idx;
                    n_pend_last = (r_left == CW'(1));
                end
                // Consume the entry read last cycle
                if (r_pend) begin
                    if (r_func == FN_INSERT) begin
                        if (rd_ge) begin
                            // Shift one entry up to open the slot
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_pend_idx + 1'b1;
                            o_mem_wdata = i_mem_rdata;
                            n_pos       = '0;
                        end else begin
                            n_pos = r_pend_idx + 1'b1;
                        end
                    end else begin
                        if (!r_found) begin
                            if (rd_eq) begin
                                n_found = 1'b1;
                                n_pos   = r_pend_idx;
                            end
                        end else begin
                            // Shift one entry down over the removed one
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_pend_idx - 1'b1;
                            o_mem_wdata = i_mem_rdata;
                        end
                        if (r_pend_last && (r_found || rd_eq)) begin
                            n_count           = r_count - 1'b1;
                            n_res.status      = ST_OK;
                            n_res.position    = POS_W'(hit_pos);
                            n_res.entry_count = CNT_W'(r_count - 1'b1);
                        end
                    end
                end
            end
            S_PUT: begin
                // Write the new entry into the open slot
                o_mem_we              = 1'b1;
                o_mem_waddr           = r_pos;
                o_mem_wdata.key       = r_key;
                o_mem_wdata.amount    = r_amt;
                n_count               = r_count + 1'b1;
                n_res.status          = ST_OK;
                n_res.position        = POS_W'(r_pos);
                n_res.entry_count     = CNT_W'(r_count + 1'b1);
            end
            S_PROBE: begin
                if (!probe_empty) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = probe_mid;
                    n_mid       = probe_mid;
                end
            end
            S_CMP: begin
                // Narrow the search window or report the hit
                if (rd_eq) begin
                    n_res.status       = ST_OK;
                    n_res.found_amount = i_mem_rdata.amount;
                    n_res.position     = POS_W'(r_mid);
                end else if (rd_gt) begin
                    n_hi = mid_s - ONE_S;
                end else begin
                    n_lo = mid_s + ONE_S;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_amt       <= n_amt;
        r_rd_idx    <= n_rd_idx;
        r_left      <= n_left;
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_res       <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/sorted_date_table_core.sv -----
// Sorted date table: up to DEPTH entries of {date key, signed amount in cents},
// kept in ascending key order in one synchronous memory.
// Input channel (i_in_valid / o_in_ready) carries one command beat: i_func picks
// insert, delete or search; the date fields form key = year*10000+month*100+day.
// Output channel (o_out_valid / i_out_ready) returns exactly one result beat per
// command: status, found amount, position and the entry count afterwards.
// Work per command, with n entries stored (the walks make one memory read per cycle):
//   insert: a walk down from the last entry that shifts entries up by one slot
//   delete: a walk over all n entries that finds and closes the gap
//   search: up to p = floor(log2(n)) + 1 probes, each a read and then a compare
//   refused, full or unused commands: no memory access
// A new command is taken once the previous result has moved into the output
// register, so the block takes the next command while that result waits.
// If the receiver stalls, the result holds in the output register and at most
// one more command completes before the input side also stalls.
// Reset clears the entry count and control state; memory contents are left as
// they are and never read before being written, so no clearing pass is run.
module sorted_date_table_core
    import sdt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [YEAR_W-1:0]       i_year,
    input  logic [MONTH_W-1:0]      i_month,
    input  logic [DAY_W-1:0]        i_day,
    input  logic signed [AMT_W-1:0] i_amount_cents,
    // Result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [AMT_W-1:0] o_found_amount,
    output logic [POS_W-1:0]        o_position,
    output logic [CNT_W-1:0]        o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             in_accept;
    logic             ctrl_idle;
    logic [KEY_W-1:0] cmd_key;
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    t_entry           mem_rdata;
    logic             r_out_valid;
    t_result          r_out;

    assign o_in_ready = ctrl_idle;
    assign in_accept  = i_in_valid & ctrl_idle;

    // Build the date key from the command beat
    sdt_keygen u_keygen (
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_key   (cmd_key)
    );

    sdt_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_func      (i_func),
        .i_key       (cmd_key),
        .i_amount    (i_amount_cents),
        .o_idle      (ctrl_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    sdt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load a finished result, drop it once the beat is taken
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found_amount = r_out.found_amount;
    assign o_position     = r_out.position;
    assign o_entry_count  = r_out.entry_count;

`ifndef SYNTHESIS
    // A failed command reports no amount and no position
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status != ST_OK) |->
            (res.found_amount == '0 && res.position == '0))
        else $error("failed result carries amount or position");

    // A full report only comes from a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status == ST_FULL) |-> (res.entry_count == CNT_W'(DEPTH)))
        else $error("full status with table not full");

    // No command is taken while a result is pending in the controller
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !o_in_ready)
        else $error("command ready while result pending");

    // An accepted command closes the input side on the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input still ready after accepting a command");
`endif

endmodule

// ----- test/sorted_date_table_core_tb.sv -----
module sorted_date_table_core_tb;
    import sdt_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int STIM_TOTAL  = 1575;
    localparam int TAIL_ITEMS  = 150;
    localparam int SETTLE      = 120;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_CAP  = 40;

    typedef struct {
        logic [FUNC_W-1:0]       fn;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic signed [AMT_W-1:0] amt;
        bit                      typed;
        t_result                 want;
    } t_cmd_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [FUNC_W-1:0]       i_func = '0;
    logic [YEAR_W-1:0]       i_year = '0;
    logic [MONTH_W-1:0]      i_month = '0;
    logic [DAY_W-1:0]        i_day = '0;
    logic signed [AMT_W-1:0] i_amount_cents = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [1:0]              o_status;
    logic signed [AMT_W-1:0] o_found_amount;
    logic [POS_W-1:0]        o_position;
    logic [CNT_W-1:0]        o_entry_count;

    // Shadow copy of the sorted table
    logic [KEY_W-1:0]        ledger_key [TABLE_DEPTH];
    logic signed [AMT_W-1:0] ledger_amt [TABLE_DEPTH];
    int                      ledger_count = 0;

    t_result  reply_q [$];
    t_cmd_row script [$];

    int errors = 0;
    int reported = 0;
    int sent_total = 0;
    int sweeps = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};

    sorted_date_table_core #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day          (i_day),
        .i_amount_cents (i_amount_cents),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_amount (o_found_amount),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Build the date key, clamping the year to its top value
    function automatic logic [KEY_W-1:0] date_key(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m,
                                                  input logic [DAY_W-1:0] d);
        logic [KEY_W-1:0] yy;
        yy = (y > YEAR_MAX) ? KEY_W'(YEAR_MAX) : KEY_W'(y);
        return yy * KEY_W'(YEAR_SCALE) + KEY_W'(m) * KEY_W'(MONTH_SCALE) + KEY_W'(d);
    endfunction

    // Apply one command to the shadow table and return the reply it gives
    function automatic t_result apply_ledger_op(input logic [FUNC_W-1:0] fn,
                                                input logic [YEAR_W-1:0] y,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [DAY_W-1:0] d,
                                                input logic signed [AMT_W-1:0] amt);
        t_result          r;
        logic [KEY_W-1:0] k;
        int               idx;
        int               lo;
        int               hi;
        int               mid;
        r = '0;
        r.status = ST_NOT_FOUND;
        k = date_key(y, m, d);
        case (fn)
            FN_INSERT: begin
                if (ledger_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    idx = 0;
                    while (idx < ledger_count && k > ledger_key[idx]) idx++;
                    for (int j = ledger_count; j > idx; j--) begin
                        ledger_key[j] = ledger_key[j-1];
                        ledger_amt[j] = ledger_amt[j-1];
                    end
                    ledger_key[idx] = k;
                    ledger_amt[idx] = amt;
                    ledger_count++;
                    r.status = ST_OK;
                    r.position = POS_W'(idx);
                end
            end
            FN_DELETE: begin
                if (ledger_count <= 1) begin
                    r.status = ST_REFUSED;
                end else begin
                    idx = 0;
                    while (idx < ledger_count && ledger_key[idx] != k) idx++;
                    if (idx < ledger_count) begin
                        for (int j = idx; j < ledger_count - 1; j++) begin
                            ledger_key[j] = ledger_key[j+1];
                            ledger_amt[j] = ledger_amt[j+1];
                        end
                        ledger_count--;
                        r.status = ST_OK;
                        r.position = POS_W'(idx);
                    end
                end
            end
            FN_SEARCH: begin
                lo = 0;
                hi = ledger_count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (k == ledger_key[mid]) begin
                        r.status = ST_OK;
                        r.found_amount = ledger_amt[mid];
                        r.position = POS_W'(mid);
                        break;
                    end else if (k < ledger_key[mid]) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_W'(ledger_count);
        return r;
    endfunction

    // Draw a command; hit_pct is the chance of reusing a stored key
    function automatic t_cmd_row random_cmd(input logic [FUNC_W-1:0] fn, input int hit_pct);
        t_cmd_row         c;
        logic [KEY_W-1:0] k;
        int               pick;
        c.fn = fn;
        c.amt = $urandom;
        c.typed = 1'b0;
        c.want = '0;
        pick = $urandom_range(99);
        if (ledger_count != 0 && pick < hit_pct) begin
            k = ledger_key[$urandom_range(ledger_count - 1)];
            c.year = YEAR_W'(k / KEY_W'(YEAR_SCALE));
            c.month = MONTH_W'((k % KEY_W'(YEAR_SCALE)) / KEY_W'(MONTH_SCALE));
            c.day = DAY_W'(k % KEY_W'(MONTH_SCALE));
            // present a clamped year in raw form now and then
            if (c.year == YEAR_MAX && $urandom_range(1) == 1) begin
                c.year = YEAR_W'($urandom_range(10000, 16383));
            end
        end else if (pick < hit_pct + (100 - hit_pct) / 2) begin
            // crowded key range: plenty of equal keys
            c.year = YEAR_W'($urandom_range(1998, 2001));
            c.month = MONTH_W'($urandom_range(1, 3));
            c.day = DAY_W'($urandom_range(0, 3));
        end else begin
            c.year = YEAR_W'($urandom_range(16383));
            c.month = MONTH_W'($urandom);
            c.day = DAY_W'($urandom);
        end
        return c;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op();
        int p;
        int ins_w;
        p = $urandom_range(99);
        ins_w = (ledger_count < 8) ? 55 : (ledger_count > 56) ? 20 : 38;
        if (p < 4) return FN_UNUSED;
        if (p < 4 + ins_w) return FN_INSERT;
        if (p < 30 + ins_w) return FN_DELETE;
        return FN_SEARCH;
    endfunction

    // Drive one command beat, hold it until taken, then log its reply
    task automatic send_cmd(input t_cmd_row c);
        t_result pred;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= c.fn;
        i_year <= c.year;
        i_month <= c.month;
        i_day <= c.day;
        i_amount_cents <= c.amt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = apply_ledger_op(c.fn, c.year, c.month, c.day, c.amt);
        reply_q.push_back(c.typed ? c.want : pred);
        op_seen[c.fn]++;
        sent_total++;
    endtask

    task automatic mixed_round(input int n);
        logic [FUNC_W-1:0] fn;
        repeat (n) begin
            fn = pick_op();
            send_cmd(random_cmd(fn, (fn == FN_INSERT) ? 30 : 60));
        end
    endtask

    // Fill the table past full, probe it, then empty it down to one entry and delete past it
    task automatic fill_and_drain();
        while (ledger_count < TABLE_DEPTH) send_cmd(random_cmd(FN_INSERT, 25));
        repeat (4) send_cmd(random_cmd(FN_INSERT, 25));
        repeat (12) send_cmd(random_cmd(FN_SEARCH, 70));
        while (ledger_count > 1) begin
            if ($urandom_range(9) == 0) begin
                send_cmd(random_cmd(FN_SEARCH, 60));
            end else begin
                send_cmd(random_cmd(FN_DELETE, 100));
            end
        end
        repeat (3) send_cmd(random_cmd(FN_DELETE, 100));
        sweeps++;
    endtask

    // Hold off the sender until every reply is back
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string label, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            reported++;
            if (reported <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, label, want_v, got_v);
            end
        end
    endtask

    // Receiver side: random stall bursts on i_out_ready
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            rx_hold <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each reply beat with the oldest pending one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            status_seen[o_status]++;
            if (reply_q.size() == 0) begin
                errors++;
                reported++;
                if (reported <= REPORT_CAP) begin
                    $display("%0t: reply beat with none pending, expected nothing, actual status %0d",
                             $time, o_status);
                end
            end else begin
                want = reply_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("found_amount", want.found_amount, o_found_amount);
                check_field("position", want.position, o_position);
                check_field("entry_count", want.entry_count, o_entry_count);
            end
        end
    end

    // Guard against a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d replies pending", $time, reply_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int round;
        round = 0;
        script = '{
            // empty table
            '{FN_SEARCH, 14'd2000, 4'd1, 5'd1, 32'sd0, 1'b1,
              '{ST_NOT_FOUND, 32'sd0, 6'd0, 7'd0}},
            '{FN_DELETE, 14'd2000, 4'd1, 5'd1, 32'sd0, 1'b1,
              '{ST_REFUSED, 32'sd0, 6'd0, 7'd0}},
            '{FN_UNUSED, 14'd16383, 4'd15, 5'd31, -32'sd1, 1'b1,
              '{ST_NOT_FOUND, 32'sd0, 6'd0, 7'd0}},
            // low key with the most negative amount
            '{FN_INSERT, 14'd0, 4'd1, 5'd0, 32'sh80000000, 1'b1,
              '{ST_OK, 32'sd0, 6'd0, 7'd1}},
            // delete with one entry stored
            '{FN_DELETE, 14'd0, 4'd1, 5'd0, 32'sd0, 1'b1,
              '{ST_REFUSED, 32'sd0, 6'd0, 7'd1}},
            // year above range clamps; largest amount
            '{FN_INSERT, 14'd16383, 4'd15, 5'd31, 32'sh7FFFFFFF, 1'b1,
              '{ST_OK, 32'sd0, 6'd1, 7'd2}},
            '{FN_SEARCH, 14'd9999, 4'd15, 5'd31, 32'sd0, 1'b1,
              '{ST_OK, 32'sh7FFFFFFF, 6'd1, 7'd2}},
            '{FN_SEARCH, 14'd12000, 4'd15, 5'd31, 32'sd0, 1'b1,
              '{ST_OK, 32'sh7FFFFFFF, 6'd1, 7'd2}},
            // equal key goes in front
            '{FN_INSERT, 14'd0, 4'd1, 5'd0, 32'sd5, 1'b1,
              '{ST_OK, 32'sd0, 6'd0, 7'd3}},
            '{FN_SEARCH, 14'd0, 4'd1, 5'd0, 32'sd0, 1'b0, '0},
            // missing key
            '{FN_DELETE, 14'd2020, 4'd6, 5'd15, 32'sd0, 1'b1,
              '{ST_NOT_FOUND, 32'sd0, 6'd0, 7'd3}},
            '{FN_SEARCH, 14'd2020, 4'd6, 5'd15, 32'sd0, 1'b1,
              '{ST_NOT_FOUND, 32'sd0, 6'd0, 7'd3}},
            // month and day outside their ranges, zero key
            '{FN_INSERT, 14'd5, 4'd0, 5'd0, 32'sd1234, 1'b0, '0},
            '{FN_INSERT, 14'd0, 4'd0, 5'd0, -32'sd7, 1'b0, '0},
            '{FN_INSERT, 14'd2024, 4'd2, 5'd29, 32'sd100, 1'b0, '0},
            '{FN_DELETE, 14'd0, 4'd1, 5'd0, 32'sd0, 1'b0, '0},
            '{FN_SEARCH, 14'd0, 4'd1, 5'd0, 32'sd0, 1'b0, '0},
            '{FN_UNUSED, 14'd2024, 4'd2, 5'd29, 32'sd9, 1'b0, '0},
            '{FN_SEARCH, 14'd0, 4'd0, 5'd0, 32'sd0, 1'b0, '0},
            '{FN_DELETE, 14'd9999, 4'd15, 5'd31, 32'sd0, 1'b0, '0},
            '{FN_INSERT, 14'd9999, 4'd12, 5'd31, 32'sd0, 1'b0, '0},
            '{FN_SEARCH, 14'd5, 4'd0, 5'd0, 32'sd0, 1'b0, '0},
            '{FN_DELETE, 14'd0, 4'd0, 5'd0, 32'sd0, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 12;
        rx_stall_pct <= 6;

        // directed beats
        foreach (script[r]) send_cmd(script[r]);
        hold_until_drained();

        // random phases, draining the block between them
        while (sent_total < STIM_TOTAL - TAIL_ITEMS) begin
            case (round % 4)
                0: begin
                    tx_idle_pct = 12;
                    rx_stall_pct <= 6;
                    mixed_round(200);
                end
                1: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                    mixed_round(120);
                end
                2: begin
                    tx_idle_pct = 8;
                    rx_stall_pct <= 4;
                    fill_and_drain();
                end
                default: begin
                    tx_idle_pct = 25;
                    rx_stall_pct <= 20;
                    mixed_round(150);
                end
            endcase
            hold_until_drained();
            round++;
        end

        // closing stretch at full rate
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        mixed_round(TAIL_ITEMS);

        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d commands: %0d insert, %0d delete, %0d search, %0d unused code, %0d full sweeps",
                 sent_total, op_seen[FN_INSERT], op_seen[FN_DELETE], op_seen[FN_SEARCH],
                 op_seen[FN_UNUSED], sweeps);
        $display("replies: %0d ok, %0d not found, %0d table full, %0d delete refused; %0d errors",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
                 status_seen[ST_REFUSED], errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
